### rtl/core/fic_pkg.sv
// Package for the frame interval classifier: field widths, register indexes,
// result codes and the transaction types shared by the core modules.
// Depends on nothing.
package fic_pkg;

    localparam int FRAME_BITS = 24;
    localparam int RATE_W     = 16;
    localparam int MODE_W     = 2;
    localparam int DIR_W      = 2;
    localparam int SEC_W      = 24;
    localparam int DEV_W      = 4;
    localparam int CLASS_W    = 2;
    localparam int CFG_IDX_W  = 2;

    // Product gap * denominator, then times 30 (below 32, so five more bits).
    localparam int PROD_W = FRAME_BITS + RATE_W;
    localparam int DIVD_W = PROD_W + 5;
    // Scaled gap plus the rounding bias.
    localparam int SCL_W  = DIVD_W + 1;

    // Division by 30 retires D30_STEP quotient bits per stage.
    localparam int SEC_DIV    = 30;
    localparam int REM30_W    = 5;
    localparam int D30_STEP   = 3;
    localparam int D30_STAGES = (SCL_W + D30_STEP - 1) / D30_STEP;
    localparam int D30_W      = D30_STAGES * D30_STEP;

    // Seconds below this width cover every value that can be classified.
    localparam int SHORT_W = 7;

    localparam logic [RATE_W-1:0] FAST_NUM   = RATE_W'(30000);
    localparam logic [RATE_W-1:0] FAST_DEN   = RATE_W'(1001);
    localparam logic [RATE_W-1:0] FAST_DIV   = RATE_W'(1000);
    localparam logic [RATE_W-1:0] RESET_NUM  = RATE_W'(30000);
    localparam logic [RATE_W-1:0] RESET_DEN  = RATE_W'(1001);
    localparam int                FAST_BIAS  = 140;
    localparam int                HALF_STEP  = 15;
    localparam int                SEC_LIMIT  = 120;
    localparam logic [SEC_W-1:0]  SEC_MAX    = {SEC_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JUDGE    = 2'd2;

    localparam logic [MODE_W-1:0] JUDGE_LOOSE  = 2'd0;
    localparam logic [MODE_W-1:0] JUDGE_SELECT = 2'd1;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
    localparam logic [DIR_W-1:0] DIR_BACK = 2'b11;

    localparam logic [CLASS_W-1:0] CLASS_NONE     = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_SECONDS  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_STANDARD = 2'd2;

    typedef struct packed {
        logic [FRAME_BITS-1:0] from_frame;
        logic [FRAME_BITS-1:0] to_frame;
    } item_in_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] direction;
        logic [SEC_W-1:0]        whole_seconds;
        logic [DEV_W-1:0]        deviation_frames;
        logic [CLASS_W-1:0]      interval_class;
    } item_out_t;

    // Data that rides along the scaling divider.
    typedef struct packed {
        logic [DIR_W-1:0]      direction;
        logic [FRAME_BITS-1:0] gap;
    } fic_side_t;

    // What the seconds divider hands back.
    typedef struct packed {
        logic [DIR_W-1:0]   direction;
        logic [D30_W-1:0]   seconds;
        logic [REM30_W-1:0] remainder;
    } fic_sec_t;

endpackage

### rtl/core/fic_scale_div.sv
// Pipelined restoring divider for the scaled frame gap, one quotient bit per
// stage. Depends on fic_pkg.
module fic_scale_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  fic_pkg::fic_side_t         in_side,
    input  logic [fic_pkg::DIVD_W-1:0] in_dividend,
    input  logic [fic_pkg::RATE_W-1:0] divisor,
    output logic                       out_valid,
    output fic_pkg::fic_side_t         out_side,
    output logic [fic_pkg::DIVD_W-1:0] out_quotient
);
    import fic_pkg::*;

    logic              valid_reg [DIVD_W];
    fic_side_t         side_reg  [DIVD_W];
    logic [DIVD_W-1:0] work_reg  [DIVD_W];
    // The last stage keeps no remainder.
    logic [RATE_W-1:0] rem_reg   [DIVD_W-1];

    generate
        for (genvar k = 0; k < DIVD_W; k++) begin : g_stage
            logic              valid_in;
            fic_side_t         side_in;
            logic [RATE_W-1:0] rem_in;
            logic [DIVD_W-1:0] work_in;
            logic [RATE_W:0]   trial;
            logic              take;
            logic [DIVD_W-1:0] work_next;

            if (k == 0) begin : g_first
                assign valid_in = in_valid;
                assign side_in  = in_side;
                assign rem_in   = '0;
                assign work_in  = in_dividend;
            end else begin : g_later
                assign valid_in = valid_reg[k-1];
                assign side_in  = side_reg[k-1];
                assign rem_in   = rem_reg[k-1];
                assign work_in  = work_reg[k-1];
            end

            // Dividend bits leave at the top while quotient bits enter below.
            assign trial     = {rem_in, work_in[DIVD_W-1]};
            assign take      = trial >= {1'b0, divisor};
            assign work_next = {work_in[DIVD_W-2:0], take};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else
                begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                side_reg[k] <= side_in;
                work_reg[k] <= work_next;
            end

            if (k < DIVD_W - 1) begin : g_rem
                logic [RATE_W-1:0] diff;
                logic [RATE_W-1:0] rem_next;

                // The trial value stays below twice the divisor, so the
                // difference fits in the remainder width.
                assign diff     = trial[RATE_W-1:0] - divisor;
                assign rem_next = take ? diff : trial[RATE_W-1:0];

                always_ff @(posedge clk)
                begin
                    rem_reg[k] <= rem_next;
                end
            end
        end
    endgenerate

    assign out_valid    = valid_reg[DIVD_W-1];
    assign out_side     = side_reg[DIVD_W-1];
    assign out_quotient = work_reg[DIVD_W-1];

endmodule

### rtl/core/fic_sec_div.sv
// Pipelined division of the biased scaled gap by 30, several quotient bits
// per stage, giving whole seconds and the remainder. Depends on fic_pkg.
module fic_sec_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [fic_pkg::DIR_W-1:0] in_dir,
    input  logic [fic_pkg::SCL_W-1:0] in_value,
    output logic                      out_valid,
    output fic_pkg::fic_sec_t         out_sec
);
    import fic_pkg::*;

    logic               valid_reg [D30_STAGES];
    logic [DIR_W-1:0]   dir_reg   [D30_STAGES];
    logic [REM30_W-1:0] rem_reg   [D30_STAGES];
    logic [D30_W-1:0]   work_reg  [D30_STAGES];

    generate
        for (genvar k = 0; k < D30_STAGES; k++) begin : g_stage
            logic               valid_in;
            logic [DIR_W-1:0]   dir_in;
            logic [REM30_W-1:0] rem_in;
            logic [D30_W-1:0]   work_in;
            logic [REM30_W-1:0] rem_next;
            logic [D30_STEP-1:0] qbits;
            logic [D30_W-1:0]   work_next;

            if (k == 0) begin : g_first
                assign valid_in = in_valid;
                assign dir_in   = in_dir;
                assign rem_in   = '0;
                assign work_in  = D30_W'(in_value);
            end else begin : g_later
                assign valid_in = valid_reg[k-1];
                assign dir_in   = dir_reg[k-1];
                assign rem_in   = rem_reg[k-1];
                assign work_in  = work_reg[k-1];
            end

            always_comb
            begin
                logic [REM30_W:0]   trial;
                logic [REM30_W-1:0] rem_v;
                rem_v = rem_in;
                qbits = '0;
                for (int j = 0; j < D30_STEP; j++)
                begin
                    trial = {rem_v, work_in[D30_W-1-j]};
                    if (trial >= (REM30_W+1)'(SEC_DIV))
                    begin
                        qbits[D30_STEP-1-j] = 1'b1;
                        rem_v = REM30_W'(trial - (REM30_W+1)'(SEC_DIV));
                    end
                    else
                    begin
                        rem_v = trial[REM30_W-1:0];
                    end
                end
                rem_next = rem_v;
            end

            assign work_next = {work_in[D30_W-D30_STEP-1:0], qbits};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else
                begin
                    valid_reg[k] <= valid_in;
                end
            end

            always_ff @(posedge clk)
            begin
                dir_reg[k]  <= dir_in;
                rem_reg[k]  <= rem_next;
                work_reg[k] <= work_next;
            end
        end
    endgenerate

    assign out_valid         = valid_reg[D30_STAGES-1];
    assign out_sec.direction = dir_reg[D30_STAGES-1];
    assign out_sec.seconds   = work_reg[D30_STAGES-1];
    assign out_sec.remainder = rem_reg[D30_STAGES-1];

endmodule

### rtl/core/frame_interval_classifier.sv
// Top level of the frame interval classifier: gap, rate scaling, rounding to
// seconds and classification. Depends on fic_pkg, fic_scale_div, fic_sec_div.
// The pipeline holds 66 register stages (5 + DIVD_W + D30_STAGES at FRAME_BITS 24).
// Throughput: one transaction per cycle; busy stays low, since the scaling
// divider and the divide-by-30 unit are fully pipelined and results are never held.
// Reset clears all valid bits and loads rate 30000/1001 with the loose rule.
module frame_interval_classifier (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  fic_pkg::item_in_t            request,
    output logic                         result_valid,
    output fic_pkg::item_out_t           result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fic_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fic_pkg::RATE_W-1:0]   cfg_data
);
    import fic_pkg::*;

    logic [RATE_W-1:0] num_reg;
    logic [RATE_W-1:0] den_reg;
    logic [MODE_W-1:0] judge_reg;

    logic              fast_rate;
    logic [RATE_W-1:0] num_eff;
    logic [RATE_W-1:0] divisor;

    logic              s1_valid_reg;
    fic_side_t         s1_side_reg;
    fic_side_t         s1_side_next;
    logic              s2_valid_reg;
    fic_side_t         s2_side_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic              s3_valid_reg;
    fic_side_t         s3_side_reg;
    logic [DIVD_W-1:0] s3_dividend_reg;
    logic [DIVD_W-1:0] s3_dividend_next;

    logic              div_valid;
    fic_side_t         div_side;
    logic [DIVD_W-1:0] div_quotient;

    logic              s4_valid_reg;
    logic [DIR_W-1:0]  s4_dir_reg;
    logic [SCL_W-1:0]  s4_value_reg;
    logic [DIVD_W-1:0] scaled;

    logic              sec_valid;
    fic_sec_t          sec_res;

    logic              result_valid_reg;
    item_out_t         result_reg;
    item_out_t         result_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg   <= RESET_NUM;
            den_reg   <= RESET_DEN;
            judge_reg <= JUDGE_LOOSE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RATE_NUM: num_reg   <= cfg_data;
                CFG_RATE_DEN: den_reg   <= cfg_data;
                CFG_JUDGE:    judge_reg <= cfg_data[MODE_W-1:0];
                default:      ;
            endcase
        end
    end

    // The user changes configuration only while the pipeline is empty; not enforced.
    assign fast_rate = (num_reg == FAST_NUM) && (den_reg == FAST_DEN);
    assign num_eff   = (num_reg == '0) ? RATE_W'(1) : num_reg;
    assign divisor   = fast_rate ? FAST_DIV : num_eff;

    // Stage 1: direction and absolute gap.
    always_comb
    begin
        if (request.to_frame > request.from_frame)
        begin
            s1_side_next.direction = DIR_FWD;
            s1_side_next.gap       = request.to_frame - request.from_frame;
        end
        else if (request.to_frame < request.from_frame)
        begin
            s1_side_next.direction = DIR_BACK;
            s1_side_next.gap       = request.from_frame - request.to_frame;
        end
        else
        begin
            s1_side_next.direction = DIR_NONE;
            s1_side_next.gap       = '0;
        end
    end

    // Stage 3: gap * den * 30 + num / 2, or gap + 140 for the fast rate.
    always_comb
    begin
        if (fast_rate)
        begin
            s3_dividend_next = DIVD_W'(s2_side_reg.gap) + DIVD_W'(FAST_BIAS);
        end
        else
        begin
            s3_dividend_next = (DIVD_W'(s2_prod_reg) << 5) - (DIVD_W'(s2_prod_reg) << 1)
                             + DIVD_W'(num_eff >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg     <= s1_side_next;
        s2_side_reg     <= s1_side_reg;
        s2_prod_reg     <= PROD_W'(s1_side_reg.gap) * PROD_W'(den_reg);
        s3_side_reg     <= s2_side_reg;
        s3_dividend_reg <= s3_dividend_next;
        s4_dir_reg      <= div_side.direction;
        s4_value_reg    <= SCL_W'(scaled) + SCL_W'(HALF_STEP);
    end

    fic_scale_div u_scale_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s3_valid_reg),
        .in_side      (s3_side_reg),
        .in_dividend  (s3_dividend_reg),
        .divisor      (divisor),
        .out_valid    (div_valid),
        .out_side     (div_side),
        .out_quotient (div_quotient)
    );

    // Stage 4: the fast rate adds the gap back to the correction term.
    assign scaled = fast_rate ? div_quotient + DIVD_W'(div_side.gap) : div_quotient;

    fic_sec_div u_sec_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .in_dir    (s4_dir_reg),
        .in_value  (s4_value_reg),
        .out_valid (sec_valid),
        .out_sec   (sec_res)
    );

    // Final stage: saturation, deviation and class.
    always_comb
    begin
        logic               short_sec;
        logic [SHORT_W-1:0] s7;
        logic [REM30_W-1:0] dev_wide;
        logic [DEV_W-1:0]   dev;
        logic [DEV_W-1:0]   lim2;
        logic [DEV_W-1:0]   lim1;
        logic               hit;

        short_sec = sec_res.seconds <= D30_W'(SEC_LIMIT);
        s7        = sec_res.seconds[SHORT_W-1:0];

        // scaled = 30 * seconds + remainder - 15, so the deviation is |remainder - 15|.
        if (sec_res.remainder >= REM30_W'(HALF_STEP))
        begin
            dev_wide = sec_res.remainder - REM30_W'(HALF_STEP);
        end
        else
        begin
            dev_wide = REM30_W'(HALF_STEP) - sec_res.remainder;
        end
        dev = dev_wide[DEV_W-1:0];

        lim2 = DEV_W'(5);
        lim1 = DEV_W'(4);
        hit  = 1'b0;
        result_next.interval_class = CLASS_NONE;

        case (judge_reg)
            JUDGE_LOOSE:
            begin
                hit = ((dev <= DEV_W'(5)) && (s7 >= SHORT_W'(3)))
                   || ((dev <= DEV_W'(10))
                       && (s7 inside {7'd10, 7'd15, 7'd30, 7'd45, 7'd60,
                                      7'd75, 7'd90, 7'd105, 7'd120}));
                result_next.interval_class = (hit && short_sec) ? CLASS_SECONDS : CLASS_NONE;
            end
            default:
            begin
                if (judge_reg == JUDGE_SELECT)
                begin
                    lim2 = DEV_W'(10);
                    lim1 = DEV_W'(5);
                end
                if (short_sec && (dev <= lim2)
                    && (s7 inside {7'd10, 7'd15, 7'd30, 7'd45, 7'd60, 7'd90, 7'd120}))
                begin
                    result_next.interval_class = CLASS_STANDARD;
                end
                else if (short_sec && (dev <= lim1) && (s7 inside {[7'd3:7'd25]}))
                begin
                    result_next.interval_class = CLASS_SECONDS;
                end
            end
        endcase

        result_next.direction        = sec_res.direction;
        result_next.whole_seconds    = (|sec_res.seconds[D30_W-1:SEC_W]) ? SEC_MAX
                                     : sec_res.seconds[SEC_W-1:0];
        result_next.deviation_frames = dev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= sec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### test/frame_interval_classifier_tb.sv
`timescale 1ns / 1ps
// Testbench for frame_interval_classifier: sends frame pairs through the command port
// and predicts every result, which is then checked field by field.
// Depends on fic_pkg and the frame_interval_classifier RTL.
module frame_interval_classifier_tb;
    import fic_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int SETTLE_CYCLES  = 80;
    localparam int RUN_LIMIT_NS   = 2_000_000;
    localparam int PRINT_LIMIT    = 50;
    localparam int PHASE_COUNT    = 12;
    localparam int PHASE_ITEMS    = 104;

    localparam logic [MODE_W-1:0] JUDGE_EXACT = 2'd2;
    localparam logic [MODE_W-1:0] JUDGE_SPARE = 2'd3;
    localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_in_t              request;
    logic                  result_valid;
    item_out_t             result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [RATE_W-1:0]     cfg_data;

    // Local copy of the rate and rule registers.
    logic [RATE_W-1:0]     rate_num;
    logic [RATE_W-1:0]     rate_den;
    logic [MODE_W-1:0]     judge_sel;

    item_out_t             pending_intervals[$];
    int                    error_count;
    int                    burst_left;
    bit                    start_high;
    bit                    steady_flow;
    int                    std_secs[7] = '{10, 15, 30, 45, 60, 90, 120};

    frame_interval_classifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [CLASS_W-1:0] classify_interval(longint unsigned secs,
                                                             longint unsigned dev);
        bit              std_len;
        longint unsigned lim_std;
        longint unsigned lim_sec;
        std_len = 1'b0;
        foreach (std_secs[k])
            if (secs == std_secs[k])
                std_len = 1'b1;
        if (judge_sel == JUDGE_LOOSE)
        begin
            if (secs <= SEC_LIMIT && ((dev <= 5 && secs >= 3) || (dev <= 10 && secs == 10) ||
                                      (dev <= 10 && secs >= 15 && secs % 15 == 0)))
                return CLASS_SECONDS;
            return CLASS_NONE;
        end
        // The unused mode falls back to the exact rule.
        lim_std = (judge_sel == JUDGE_SELECT) ? 10 : 5;
        lim_sec = (judge_sel == JUDGE_SELECT) ? 5 : 4;
        if (dev <= lim_std && std_len)
            return CLASS_STANDARD;
        if (dev <= lim_sec && secs >= 3 && secs <= 25)
            return CLASS_SECONDS;
        return CLASS_NONE;
    endfunction

    function automatic item_out_t predict_interval(item_in_t pair);
        item_out_t       r;
        longint unsigned gap;
        longint unsigned scaled;
        longint unsigned secs;
        longint unsigned dev;
        longint unsigned divisor;
        if (pair.to_frame > pair.from_frame)
        begin
            gap = pair.to_frame - pair.from_frame;
            r.direction = DIR_FWD;
        end
        else if (pair.to_frame < pair.from_frame)
        begin
            gap = pair.from_frame - pair.to_frame;
            r.direction = DIR_BACK;
        end
        else
        begin
            gap = 0;
            r.direction = DIR_NONE;
        end
        if (rate_num == FAST_NUM && rate_den == FAST_DEN)
            scaled = gap + (gap + FAST_BIAS) / FAST_DIV;
        else
        begin
            divisor = (rate_num == 0) ? 1 : rate_num;
            scaled = (gap * rate_den * SEC_DIV + divisor / 2) / divisor;
        end
        secs = (scaled + HALF_STEP) / SEC_DIV;
        dev = (secs * SEC_DIV >= scaled) ? secs * SEC_DIV - scaled : scaled - secs * SEC_DIV;
        r.whole_seconds = (secs > SEC_MAX) ? SEC_MAX : secs[SEC_W-1:0];
        r.deviation_frames = dev[DEV_W-1:0];
        r.interval_class = classify_interval(secs, dev);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : check_results
        item_out_t want;
        if (rst_n && result_valid !== 1'b0)
        begin
            if (pending_intervals.size() == 0)
                report_mismatch($sformatf("result %h with no transaction outstanding", result));
            else
            begin
                want = pending_intervals.pop_front();
                if (result.direction !== want.direction)
                    report_mismatch($sformatf("direction %0d, want %0d",
                                              result.direction, want.direction));
                if (result.whole_seconds !== want.whole_seconds)
                    report_mismatch($sformatf("whole_seconds %0d, want %0d",
                                              result.whole_seconds, want.whole_seconds));
                if (result.deviation_frames !== want.deviation_frames)
                    report_mismatch($sformatf("deviation_frames %0d, want %0d",
                                              result.deviation_frames, want.deviation_frames));
                if (result.interval_class !== want.interval_class)
                    report_mismatch($sformatf("interval_class %0d, want %0d",
                                              result.interval_class, want.interval_class));
            end
        end
    end

    // Sends one pair; start stays high across a burst and drops for a random gap
    // between bursts unless the current phase runs without idling.
    task automatic send_pair(input logic [FRAME_BITS-1:0] from_f,
                             input logic [FRAME_BITS-1:0] to_f);
        item_in_t pair;
        pair.from_frame = from_f;
        pair.to_frame = to_f;
        if (start_high && burst_left == 0 && !steady_flow)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        if (burst_left == 0)
            burst_left = $urandom_range(1, 40);
        burst_left--;
        start <= 1'b1;
        request <= pair;
        start_high = 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        pending_intervals.push_back(predict_interval(pair));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        start_high = 1'b0;
        do @(posedge clk); while (pending_intervals.size() != 0);
    endtask

    task automatic load_config(input logic [RATE_W-1:0] num, input logic [RATE_W-1:0] den,
                               input logic [MODE_W-1:0] mode);
        logic [CFG_IDX_W-1:0] regs[3];
        logic [RATE_W-1:0]    values[3];
        regs = '{CFG_RATE_NUM, CFG_RATE_DEN, CFG_JUDGE};
        values = '{num, den, RATE_W'(mode)};
        wait_idle();
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= values[i];
            do @(posedge clk); while (cfg_ready !== 1'b1);
        end
        cfg_valid <= 1'b0;
        rate_num = num;
        rate_den = den;
        judge_sel = mode;
    endtask

    // Mostly gaps near a whole number of seconds at the current rate, so that
    // every class is reached; the rest are short gaps and fully random pairs.
    task automatic send_random_pair();
        longint unsigned       gap;
        longint unsigned       secs;
        logic [FRAME_BITS-1:0] from_f;
        logic [FRAME_BITS-1:0] to_f;
        int                    pick;
        pick = $urandom_range(0, 9);
        from_f = FRAME_BITS'($urandom);
        to_f = FRAME_BITS'($urandom);
        if (pick >= 2)
        begin
            if (pick < 4 || rate_den == 0)
                gap = $urandom_range(0, 4000);
            else
            begin
                if ($urandom_range(0, 2) == 0)
                    secs = std_secs[$urandom_range(0, 6)];
                else
                    secs = $urandom_range(0, 130);
                gap = (secs * rate_num + rate_den / 2) / rate_den;
                gap = gap + $urandom_range(0, 8);
                gap = (gap >= 4) ? gap - 4 : 0;
                if (gap > FRAME_MAX)
                    gap = FRAME_MAX;
            end
            if ($urandom_range(0, 1))
            begin
                if (from_f > FRAME_MAX - gap)
                    from_f = FRAME_BITS'(FRAME_MAX - gap);
                to_f = FRAME_BITS'(from_f + gap);
            end
            else
            begin
                if (from_f < gap)
                    from_f = FRAME_BITS'(gap);
                to_f = FRAME_BITS'(from_f - gap);
            end
        end
        send_pair(from_f, to_f);
    endtask

    // Register values out of reset, with the fast 30000/1001 path and the loose rule.
    task automatic test_reset_defaults();
        send_pair('0, '0);
        send_pair('0, FRAME_MAX);
        send_pair(FRAME_MAX, '0);
        send_pair(24'd100, 24'd101);
        send_pair(24'd1000, 24'd700);
        send_pair(24'd0, 24'd90);
        // A gap halfway between whole seconds rounds up and gives the largest deviation.
        send_pair(24'd0, 24'd75);
        send_pair(24'd0, 24'd3596);
        send_pair(24'd0, 24'd3626);
    endtask

    task automatic test_judge_rules();
        logic [MODE_W-1:0]     modes[3];
        logic [FRAME_BITS-1:0] gaps[4];
        modes = '{JUDGE_SELECT, JUDGE_EXACT, JUDGE_SPARE};
        gaps = '{24'd3596, 24'd450, 24'd775, 24'd306};
        foreach (modes[m])
        begin
            load_config(FAST_NUM, FAST_DEN, modes[m]);
            foreach (gaps[g])
                send_pair(24'd5000, 24'd5000 + gaps[g]);
        end
    endtask

    task automatic test_rate_extremes();
        // A zero numerator divides by one instead.
        load_config('0, FAST_DEN, JUDGE_LOOSE);
        send_pair(24'd0, 24'd5);
        send_pair(FRAME_MAX, 24'd0);
        // A zero denominator scales every gap to nothing.
        load_config(FAST_NUM, '0, JUDGE_SELECT);
        send_pair(24'd7, 24'd123456);
        // The slowest rate with the longest gap saturates the seconds.
        load_config(RATE_W'(1), {RATE_W{1'b1}}, JUDGE_EXACT);
        send_pair(24'd0, FRAME_MAX);
        load_config({RATE_W{1'b1}}, RATE_W'(1), JUDGE_SPARE);
        send_pair(FRAME_MAX, FRAME_MAX - 24'd655350);
        send_pair(24'd0, 24'd1);
    endtask

    task automatic test_random_traffic();
        logic [RATE_W-1:0] phase_num[PHASE_COUNT];
        logic [RATE_W-1:0] phase_den[PHASE_COUNT];
        logic [MODE_W-1:0] mode_cycle[4];
        phase_num = '{16'd30000, 16'd25, 16'd30, 16'd24000, 16'd60000, 16'd65535,
                      16'd1, 16'd65535, 16'd60000, 16'd0, 16'd30, 16'd0};
        phase_den = '{16'd1001, 16'd1, 16'd1, 16'd1001, 16'd1001, 16'd1,
                      16'd65535, 16'd65535, 16'd2002, 16'd1, 16'd0, 16'd0};
        mode_cycle = '{JUDGE_LOOSE, JUDGE_SELECT, JUDGE_EXACT, JUDGE_SPARE};
        phase_num[PHASE_COUNT-1] = RATE_W'($urandom_range(1, 65535));
        phase_den[PHASE_COUNT-1] = RATE_W'($urandom_range(1, 65535));
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            load_config(phase_num[p], phase_den[p], mode_cycle[p % 4]);
            steady_flow = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            repeat (PHASE_ITEMS) send_random_pair();
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rate_num = RESET_NUM;
        rate_den = RESET_DEN;
        judge_sel = JUDGE_LOOSE;
        error_count = 0;
        burst_left = 0;
        start_high = 1'b0;
        steady_flow = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_judge_rules();
        test_rate_extremes();
        test_random_traffic();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### frame_interval_classifier.f
rtl/core/fic_pkg.sv
rtl/core/fic_scale_div.sv
rtl/core/fic_sec_div.sv
rtl/core/frame_interval_classifier.sv
test/frame_interval_classifier_tb.sv
